// ----- design/uerz_pkg.sv -----
package uerz_pkg;

  localparam int WIDTH_W  = 16;
  localparam int PERIOD_W = 20;
  localparam int PULSE_W  = 4;
  localparam int INDEX_W  = 3;
  localparam int CFG_W    = 20;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 40;

  typedef enum logic [INDEX_W-1:0] {
    REG_ZONE_LIMIT_RED    = 3'd0,
    REG_ZONE_LIMIT_ORANGE = 3'd1,
    REG_ZONE_LIMIT_YELLOW = 3'd2,
    REG_ZONE_LIMIT_GREEN  = 3'd3,
    REG_BEEP_LIMIT_NEAR   = 3'd4,
    REG_BEEP_LIMIT_FAR    = 3'd5,
    REG_TRIGGER_PERIOD    = 3'd6
  } reg_index_t;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_FAST = 2'd1;
  localparam logic [1:0] BEEP_SLOW = 2'd2;

  localparam logic [2:0] ZONE_RED    = 3'd0;
  localparam logic [2:0] ZONE_ORANGE = 3'd1;
  localparam logic [2:0] ZONE_YELLOW = 3'd2;
  localparam logic [2:0] ZONE_GREEN  = 3'd3;
  localparam logic [2:0] ZONE_OFF    = 3'd4;

  localparam logic [WIDTH_W-1:0]  RST_ZONE_LIMIT_RED    = 16'd1160;
  localparam logic [WIDTH_W-1:0]  RST_ZONE_LIMIT_ORANGE = 16'd2320;
  localparam logic [WIDTH_W-1:0]  RST_ZONE_LIMIT_YELLOW = 16'd4640;
  localparam logic [WIDTH_W-1:0]  RST_ZONE_LIMIT_GREEN  = 16'd9280;
  localparam logic [WIDTH_W-1:0]  RST_BEEP_LIMIT_NEAR   = 16'd1160;
  localparam logic [WIDTH_W-1:0]  RST_BEEP_LIMIT_FAR    = 16'd2320;
  localparam logic [PERIOD_W-1:0] RST_TRIGGER_PERIOD    = 20'd60000;

  typedef struct packed {
    logic               done;
    logic [WIDTH_W-1:0] width;
  } echo_result_t;

endpackage

// ----- design/uerz_echo_timer.sv -----
module uerz_echo_timer #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  level,
  output uerz_pkg::echo_result_t result
);
  import uerz_pkg::*;

  localparam int CNT_W = (COUNT_BITS >= WIDTH_W) ? WIDTH_W : COUNT_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic             busy;
  logic             busy_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    busy_next    = busy;
    count_next   = count;
    result.done  = 1'b0;
    result.width = '0;
    if (level) begin
      busy_next = 1'b1;
      if (!busy) begin
        count_next = CNT_W'(1);
      end else if (count != CNT_MAX) begin
        count_next = count + CNT_W'(1);
      end
    end else if (busy) begin
      busy_next    = 1'b0;
      count_next   = '0;
      result.done  = 1'b1;
      result.width = WIDTH_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (advance) begin
      busy  <= busy_next;
      count <= count_next;
    end
  end

endmodule

// ----- design/ultrasonic_echo_ranger_zones_unit.sv -----
// Channel  Dir  Handshake                      Content
// s_axis   in   s_axis_tvalid / s_axis_tready  echo levels of one tick
// m_axis   out  m_axis_tvalid / m_axis_tready  trigger, echo widths, beep and zone codes
// cfg      in   cfg_valid / cfg_ready          limit and period registers
//
// One item per cycle unless the output stalls; a result shows in the next cycle.
// The single output register refills in the cycle it is drained.
// Reset clears all timing state and loads the register defaults.
// A stalled output holds s_axis_tready low; cfg_ready is always high.
module ultrasonic_echo_ranger_zones_unit #(
  parameter int TRIG_WIDTH = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] echo_front, [1] echo_back, [7:2] zero
  input  logic [uerz_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] trigger_level, [1] front_done, [17:2] front_width, [19:18] beep_code,
  // [20] back_done, [36:21] back_width, [39:37] led_zone
  output logic [uerz_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uerz_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [uerz_pkg::CFG_W-1:0]     cfg_data
);
  import uerz_pkg::*;

  logic [WIDTH_W-1:0]  zone_limit_red;
  logic [WIDTH_W-1:0]  zone_limit_orange;
  logic [WIDTH_W-1:0]  zone_limit_yellow;
  logic [WIDTH_W-1:0]  zone_limit_green;
  logic [WIDTH_W-1:0]  beep_limit_near;
  logic [WIDTH_W-1:0]  beep_limit_far;
  logic [PERIOD_W-1:0] trigger_period;

  logic [PERIOD_W-1:0] period_count;
  logic [PERIOD_W-1:0] period_count_next;
  logic [PULSE_W-1:0]  pulse_count;
  logic [PULSE_W-1:0]  pulse_count_next;
  logic [PULSE_W-1:0]  pulse_load;
  logic                trig;
  logic                accept;
  logic [1:0]          beep;
  logic [2:0]          zone;
  echo_result_t        front;
  echo_result_t        back;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_limit_red    <= RST_ZONE_LIMIT_RED;
      zone_limit_orange <= RST_ZONE_LIMIT_ORANGE;
      zone_limit_yellow <= RST_ZONE_LIMIT_YELLOW;
      zone_limit_green  <= RST_ZONE_LIMIT_GREEN;
      beep_limit_near   <= RST_BEEP_LIMIT_NEAR;
      beep_limit_far    <= RST_BEEP_LIMIT_FAR;
      trigger_period    <= RST_TRIGGER_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZONE_LIMIT_RED:    zone_limit_red    <= cfg_data[WIDTH_W-1:0];
        REG_ZONE_LIMIT_ORANGE: zone_limit_orange <= cfg_data[WIDTH_W-1:0];
        REG_ZONE_LIMIT_YELLOW: zone_limit_yellow <= cfg_data[WIDTH_W-1:0];
        REG_ZONE_LIMIT_GREEN:  zone_limit_green  <= cfg_data[WIDTH_W-1:0];
        REG_BEEP_LIMIT_NEAR:   beep_limit_near   <= cfg_data[WIDTH_W-1:0];
        REG_BEEP_LIMIT_FAR:    beep_limit_far    <= cfg_data[WIDTH_W-1:0];
        REG_TRIGGER_PERIOD:    trigger_period    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pulse_load       = (period_count == '0) ? PULSE_W'(TRIG_WIDTH) : pulse_count;
    trig             = (pulse_load != '0);
    pulse_count_next = trig ? pulse_load - PULSE_W'(1) : pulse_load;
    if (({1'b0, period_count} + (PERIOD_W+1)'(1)) >= {1'b0, trigger_period}) begin
      period_count_next = '0;
    end else begin
      period_count_next = period_count + PERIOD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      pulse_count  <= '0;
    end else if (accept) begin
      period_count <= period_count_next;
      pulse_count  <= pulse_count_next;
    end
  end

  uerz_echo_timer #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .level   (s_axis_tdata[0]),
    .result  (front)
  );

  uerz_echo_timer #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .level   (s_axis_tdata[1]),
    .result  (back)
  );

  always_comb begin
    beep = BEEP_NONE;
    if (front.done) begin
      priority if (front.width < beep_limit_near) begin
        beep = BEEP_FAST;
      end else if (front.width < beep_limit_far) begin
        beep = BEEP_SLOW;
      end else begin
        beep = BEEP_NONE;
      end
    end
  end

  always_comb begin
    zone = ZONE_OFF;
    if (back.done) begin
      priority if (back.width < zone_limit_red) begin
        zone = ZONE_RED;
      end else if (back.width < zone_limit_orange) begin
        zone = ZONE_ORANGE;
      end else if (back.width < zone_limit_yellow) begin
        zone = ZONE_YELLOW;
      end else if (back.width < zone_limit_green) begin
        zone = ZONE_GREEN;
      end else begin
        zone = ZONE_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {zone, back.width, back.done, beep, front.width, front.done, trig};
    end
  end

endmodule

// ----- design/uerz_checker.sv -----
module uerz_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [uerz_pkg::OUT_W-1:0]   m_axis_tdata
);
  import uerz_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked without an output stall");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[1] |->
      m_axis_tdata[17:2] == '0 && m_axis_tdata[19:18] == BEEP_NONE)
    else $error("front fields set without a finished echo");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[20] |->
      m_axis_tdata[36:21] == '0 && m_axis_tdata[39:37] == ZONE_OFF)
    else $error("back fields set without a finished echo");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[19:18] != 2'd3 &&
      (m_axis_tdata[39:37] == ZONE_RED || m_axis_tdata[39:37] == ZONE_ORANGE ||
       m_axis_tdata[39:37] == ZONE_YELLOW || m_axis_tdata[39:37] == ZONE_GREEN ||
       m_axis_tdata[39:37] == ZONE_OFF))
    else $error("beep or zone code out of range");

endmodule

bind ultrasonic_echo_ranger_zones_unit uerz_checker u_uerz_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uerz_pkg::*;

  localparam int TRIG_WIDTH = 10;
  localparam int COUNT_BITS = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [WIDTH_W-1:0] CNT_MAX =
    (COUNT_BITS >= WIDTH_W) ? {WIDTH_W{1'b1}} : WIDTH_W'((1 << COUNT_BITS) - 1);

  // fields from the highest bit down, as packed on m_axis_tdata
  typedef struct packed {
    logic [2:0]         zone;
    logic [WIDTH_W-1:0] bw;
    logic               bdone;
    logic [1:0]         beep;
    logic [WIDTH_W-1:0] fw;
    logic               fdone;
    logic               trig;
  } reading_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  logic                idle_on = 1'b1;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  reading_t            expected_readings[$];

  logic [WIDTH_W-1:0]  lim_red = RST_ZONE_LIMIT_RED;
  logic [WIDTH_W-1:0]  lim_orange = RST_ZONE_LIMIT_ORANGE;
  logic [WIDTH_W-1:0]  lim_yellow = RST_ZONE_LIMIT_YELLOW;
  logic [WIDTH_W-1:0]  lim_green = RST_ZONE_LIMIT_GREEN;
  logic [WIDTH_W-1:0]  lim_near = RST_BEEP_LIMIT_NEAR;
  logic [WIDTH_W-1:0]  lim_far = RST_BEEP_LIMIT_FAR;
  logic [PERIOD_W-1:0] trig_period = RST_TRIGGER_PERIOD;
  logic [PERIOD_W-1:0] period_cnt = '0;
  logic [PULSE_W-1:0]  pulse_left = '0;
  logic [1:0]          echo_busy = '0;
  logic [WIDTH_W-1:0]  echo_cnt [2] = '{default: '0};

  ultrasonic_echo_ranger_zones_unit #(
    .TRIG_WIDTH(TRIG_WIDTH),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic reading_t predict_reading(input logic [1:0] levels);
    reading_t           r;
    logic [1:0]         done;
    logic [WIDTH_W-1:0] w [2];
    r = '0;
    done = '0;
    w[0] = '0;
    w[1] = '0;
    if (period_cnt == 0) begin
      pulse_left = PULSE_W'(TRIG_WIDTH);
    end
    r.trig = (pulse_left != 0);
    if (r.trig) begin
      pulse_left = pulse_left - PULSE_W'(1);
    end
    if ({1'b0, period_cnt} + 21'd1 >= {1'b0, trig_period}) begin
      period_cnt = '0;
    end else begin
      period_cnt = period_cnt + PERIOD_W'(1);
    end
    for (int ch = 0; ch < 2; ch++) begin
      if (levels[ch]) begin
        if (!echo_busy[ch]) begin
          echo_busy[ch] = 1'b1;
          echo_cnt[ch] = 16'd1;
        end else if (echo_cnt[ch] != CNT_MAX) begin
          echo_cnt[ch] = echo_cnt[ch] + WIDTH_W'(1);
        end
      end else if (echo_busy[ch]) begin
        echo_busy[ch] = 1'b0;
        done[ch] = 1'b1;
        w[ch] = echo_cnt[ch];
        echo_cnt[ch] = '0;
      end
    end
    r.fdone = done[0];
    r.fw = w[0];
    r.beep = BEEP_NONE;
    if (done[0]) begin
      if (w[0] < lim_near) r.beep = BEEP_FAST;
      else if (w[0] < lim_far) r.beep = BEEP_SLOW;
    end
    r.bdone = done[1];
    r.bw = w[1];
    r.zone = ZONE_OFF;
    if (done[1]) begin
      if (w[1] < lim_red) r.zone = ZONE_RED;
      else if (w[1] < lim_orange) r.zone = ZONE_ORANGE;
      else if (w[1] < lim_yellow) r.zone = ZONE_YELLOW;
      else if (w[1] < lim_green) r.zone = ZONE_GREEN;
    end
    return r;
  endfunction

  // bit 0 front level, bit 1 back level
  task automatic send_tick(input logic [1:0] levels);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W-2){1'b0}}, levels};
    do @(posedge clk); while (!s_axis_tready);
    expected_readings.push_back(predict_reading(levels));
  endtask

  task automatic drain_readings();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ZONE_LIMIT_RED:    lim_red = value[WIDTH_W-1:0];
      REG_ZONE_LIMIT_ORANGE: lim_orange = value[WIDTH_W-1:0];
      REG_ZONE_LIMIT_YELLOW: lim_yellow = value[WIDTH_W-1:0];
      REG_ZONE_LIMIT_GREEN:  lim_green = value[WIDTH_W-1:0];
      REG_BEEP_LIMIT_NEAR:   lim_near = value[WIDTH_W-1:0];
      REG_BEEP_LIMIT_FAR:    lim_far = value[WIDTH_W-1:0];
      REG_TRIGGER_PERIOD:    trig_period = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input int red, orange, yellow, green, near, far);
    drain_readings();
    write_reg(REG_ZONE_LIMIT_RED, CFG_W'(red));
    write_reg(REG_ZONE_LIMIT_ORANGE, CFG_W'(orange));
    write_reg(REG_ZONE_LIMIT_YELLOW, CFG_W'(yellow));
    write_reg(REG_ZONE_LIMIT_GREEN, CFG_W'(green));
    write_reg(REG_BEEP_LIMIT_NEAR, CFG_W'(near));
    write_reg(REG_BEEP_LIMIT_FAR, CFG_W'(far));
  endtask

  task automatic set_period(input int period);
    drain_readings();
    write_reg(REG_TRIGGER_PERIOD, CFG_W'(period));
  endtask

  task automatic send_pulse(input logic [1:0] levels, input int width);
    repeat (width) send_tick(levels);
    send_tick(2'b00);
  endtask

  // independent high/low runs per channel, with some single-tick noise
  task automatic run_echo_traffic(input int n, input int max_high);
    int         left [2];
    logic [1:0] lvl;
    logic [1:0] tick;
    left[0] = 0;
    left[1] = 0;
    lvl = '0;
    repeat (n) begin
      for (int ch = 0; ch < 2; ch++) begin
        if (left[ch] == 0) begin
          lvl[ch] = ~lvl[ch];
          left[ch] = lvl[ch] ? $urandom_range(max_high, 1) : $urandom_range(8, 1);
        end
        left[ch]--;
      end
      tick = lvl;
      if ($urandom_range(99) < 5) begin
        tick[1'($urandom_range(1, 0))] = 1'($urandom_range(1, 0));
      end
      send_tick(tick);
    end
  endtask

  task automatic test_reset_defaults();
    logic [1:0] seq [] = '{2'b00, 2'b01, 2'b00, 2'b10, 2'b00, 2'b11, 2'b11, 2'b00,
                           2'b11, 2'b01, 2'b00, 2'b10, 2'b11, 2'b01, 2'b10, 2'b00,
                           2'b01, 2'b01, 2'b01, 2'b10, 2'b00, 2'b00};
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  task automatic test_long_echo();
    send_pulse(2'b11, 300);
    send_pulse(2'b01, 3);
  endtask

  task automatic test_limit_boundaries();
    set_limits(2, 4, 6, 8, 3, 6);
    set_period(16);
    for (int w = 1; w <= 9; w++) send_pulse(2'b11, w);
  endtask

  task automatic test_unordered_limits();
    set_limits(10, 5, 20, 15, 8, 4);
    for (int w = 3; w <= 21; w += 3) begin
      send_pulse(2'b11, w);
    end
  endtask

  task automatic test_limit_extremes();
    set_limits(0, 0, 0, 0, 0, 0);
    send_pulse(2'b11, 1);
    send_pulse(2'b11, 3);
    set_limits('hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF);
    set_period('hFFFFF);
    // unmapped index, must leave every register alone
    write_reg(REG_UNUSED, 20'h00005);
    send_pulse(2'b11, 1);
    send_pulse(2'b01, 2);
    send_pulse(2'b10, 2);
  endtask

  task automatic test_short_periods();
    int periods [] = '{0, 1, TRIG_WIDTH, TRIG_WIDTH + 1, 5, 16};
    foreach (periods[i]) begin
      set_period(periods[i]);
      run_echo_traffic(30, 4);
    end
  endtask

  task automatic test_random_traffic();
    set_limits(10, 20, 35, 50, 15, 40);
    set_period(37);
    run_echo_traffic(250, 60);
    idle_on = 1'b0;
    set_limits($urandom_range(80), $urandom_range(80), $urandom_range(80),
               $urandom_range(80), $urandom_range(80), $urandom_range(80));
    set_period($urandom_range(60, 16));
    run_echo_traffic(200, 60);
    idle_on = 1'b1;
    set_limits($urandom_range(250), $urandom_range(250), $urandom_range(250),
               $urandom_range(250), $urandom_range(250), $urandom_range(250));
    set_period('hFFFFF);
    run_echo_traffic(200, 200);
    set_limits($urandom_range(30), $urandom_range(30), $urandom_range(30),
               $urandom_range(30), $urandom_range(30), $urandom_range(30));
    set_period($urandom_range(20));
    run_echo_traffic(200, 25);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
  end

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = reading_t'(m_axis_tdata);
      if (expected_readings.size() == 0) begin
        if (mismatches < 10) $display("%0t unexpected reading %h", $realtime, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (got.trig !== want.trig || got.fdone !== want.fdone || got.fw !== want.fw ||
            got.beep !== want.beep || got.bdone !== want.bdone || got.bw !== want.bw ||
            got.zone !== want.zone) begin
          if (mismatches < 10) begin
            $display("%0t exp trig=%0d fdone=%0d fw=%0d beep=%0d bdone=%0d bw=%0d zone=%0d",
                     $realtime, want.trig, want.fdone, want.fw, want.beep,
                     want.bdone, want.bw, want.zone);
            $display("%0t got trig=%0d fdone=%0d fw=%0d beep=%0d bdone=%0d bw=%0d zone=%0d",
                     $realtime, got.trig, got.fdone, got.fw, got.beep,
                     got.bdone, got.bw, got.zone);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_long_echo();
    test_limit_boundaries();
    test_unordered_limits();
    test_limit_extremes();
    test_short_periods();
    test_random_traffic();
    drain_readings();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/uerz_pkg.sv
design/uerz_echo_timer.sv
design/ultrasonic_echo_ranger_zones_unit.sv
design/uerz_checker.sv
verif/tb_top.sv
